// ----- src/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion - shared types
// Element and result widths, lane count and the side-band record that
// travels with each transaction through the pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int QUAT_W = 16;
    localparam int NLANE  = 4;
    localparam int NELEM  = 9;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic             vld;
        logic             deg;
        logic [NLANE-1:0] neg;
    } t_side;

endpackage

// ----- src/rmq_front.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion - front end
// Picks the branch, forms the integer vector, squares its components and
// sums the norm over three register stages.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int AW        = 19,
    parameter int NW        = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rmq_pkg::t_elem       i_m [rmq_pkg::NELEM],
    output logic [2*AW-1:0]      o_a2 [rmq_pkg::NLANE],
    output logic [NW-1:0]        o_n,
    output rmq_pkg::t_side       o_side
);
    import rmq_pkg::*;

    localparam int RW = AW + 1;
    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic signed [RW-1:0] ONE_S = RW'(ONE64);

    logic signed [RW-1:0] e [NELEM];
    logic signed [RW-1:0] t;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] n_v [NLANE];

    logic signed [RW-1:0] r_v [NLANE];
    logic                 r_vld1;
    logic                 r_deg1;

    logic [AW-1:0]        a [NLANE];
    logic [2*AW-1:0]      r_a2 [NLANE];
    logic [NLANE-1:0]     r_neg2;
    logic                 r_vld2;
    logic                 r_deg2;

    logic [NW-1:0]        n_sum;
    logic [2*AW-1:0]      r_a2_3 [NLANE];
    logic [NW-1:0]        r_n3;
    logic [NLANE-1:0]     r_neg3;
    logic                 r_vld3;
    logic                 r_deg3;

    always_comb begin
        for (int i = 0; i < NELEM; i++) begin
            e[i] = RW'(i_m[i]);
        end
        t = e[0] + e[4] + e[8];
        if (t > 0) begin
            r      = t + ONE_S;
            n_v[0] = r;
            n_v[1] = e[7] - e[5];
            n_v[2] = e[2] - e[6];
            n_v[3] = e[3] - e[1];
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            r      = ONE_S + e[0] - e[4] - e[8];
            n_v[0] = e[7] - e[5];
            n_v[1] = r;
            n_v[2] = e[1] + e[3];
            n_v[3] = e[2] + e[6];
        end else if (e[4] > e[8]) begin
            r      = ONE_S + e[4] - e[0] - e[8];
            n_v[0] = e[2] - e[6];
            n_v[1] = e[1] + e[3];
            n_v[2] = r;
            n_v[3] = e[5] + e[7];
        end else begin
            r      = ONE_S + e[8] - e[0] - e[4];
            n_v[0] = e[3] - e[1];
            n_v[1] = e[2] + e[6];
            n_v[2] = e[5] + e[7];
            n_v[3] = r;
        end
    end

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            a[i] = r_v[i][RW-1] ? AW'(-r_v[i]) : AW'(r_v[i]);
        end
        n_sum = '0;
        for (int i = 0; i < NLANE; i++) begin
            n_sum = n_sum + NW'(r_a2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_deg1 <= !(r > 0);
            for (int i = 0; i < NLANE; i++) begin
                r_a2[i]   <= a[i] * a[i];
                r_neg2[i] <= r_v[i][RW-1];
            end
            r_deg2 <= r_deg1;
            r_a2_3 <= r_a2;
            r_n3   <= n_sum;
            r_neg3 <= r_neg2;
            r_deg3 <= r_deg2 || (n_sum == '0);
        end
    end

    assign o_a2       = r_a2_3;
    assign o_n        = r_n3;
    assign o_side.vld = r_vld3;
    assign o_side.deg = r_deg3;
    assign o_side.neg = r_neg3;

endmodule

// ----- src/rmq_div.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion - pipelined divider
// Restoring division of 4*a^2*2^(2F) by the norm, one quotient bit per
// register stage.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int AW = 19,
    parameter int NW = 40,
    parameter int QW = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2*AW-1:0]  i_a2,
    input  logic [NW-1:0]    i_n,
    output logic [QW-1:0]    o_q
);
    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_q   [QW];
    logic [NW-1:0] r_n   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [NW-1:0] n_in;
        logic          bit_in;
        logic [NW:0]   sh;
        logic [NW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = NW'(i_a2 >> 1);
            assign q_in   = '0;
            assign n_in   = i_n;
            assign bit_in = i_a2[0];
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign n_in   = r_n[k-1];
            assign bit_in = 1'b0;
        end

        assign sh   = {rem_in, bit_in};
        assign diff = sh - {1'b0, n_in};
        assign ge   = sh >= {1'b0, n_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[NW-1:0] : sh[NW-1:0];
                r_q[k]   <= {q_in[QW-2:0], ge};
                r_n[k]   <= n_in;
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

// ----- src/rmq_isqrt.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion - pipelined square root
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rmq_isqrt #(
    parameter int QW = 31,
    parameter int SW = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [QW-1:0]  i_x,
    output logic [SW-1:0]  o_root
);
    localparam int PW  = 2 * SW;
    localparam int RMW = SW + 2;

    logic [RMW-1:0] r_rem  [SW];
    logic [SW-1:0]  r_root [SW];
    logic [PW-1:0]  r_x    [SW];

    for (genvar j = 0; j < SW; j++) begin : g_stage
        logic [RMW-1:0] rem_in;
        logic [SW-1:0]  root_in;
        logic [PW-1:0]  x_in;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = PW'(i_x);
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign x_in    = r_x[j-1];
        end

        assign rem_sh = {rem_in[RMW-3:0], x_in[PW-1:PW-2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[j] <= {root_in[SW-2:0], ge};
                r_x[j]    <= {x_in[PW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SW-1];

endmodule

// ----- src/rotation_matrix_to_quaternion_top.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion - top level
// Pipeline: three front stages, 2*FRAC_BITS+3 divider stages,
// FRAC_BITS+2 root stages and the output register.
// Throughput: one transaction per cycle; a stall freezes the whole pipe.
// Reset: synchronous, clears every valid bit; data registers keep values.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_00,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_01,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_02,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_10,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_11,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_12,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_20,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_21,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m_22,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [rmq_pkg::QUAT_W-1:0] o_quat_w,
    output logic signed [rmq_pkg::QUAT_W-1:0] o_quat_x,
    output logic signed [rmq_pkg::QUAT_W-1:0] o_quat_y,
    output logic signed [rmq_pkg::QUAT_W-1:0] o_quat_z,
    output logic                          o_degenerate
);
    import rmq_pkg::*;

    localparam int AW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int NW  = 2 * AW + 2;
    localparam int QW  = 2 * FRAC_BITS + 3;
    localparam int SW  = FRAC_BITS + 2;
    localparam int OW  = ((SW + 1) > QUAT_W) ? (SW + 1) : QUAT_W;
    localparam int LAT = QW + SW;
    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic [QUAT_W-1:0] ONE_Q = ONE64[QUAT_W-1:0];

    logic            en;
    t_elem           w_m [NELEM];
    logic [2*AW-1:0] w_a2 [NLANE];
    logic [NW-1:0]   w_n;
    t_side           w_side;
    logic [SW-1:0]   w_root [NLANE];
    logic [QUAT_W-1:0] n_quat [NLANE];

    t_side             r_side [LAT];
    logic              r_out_vld;
    logic [QUAT_W-1:0] r_quat [NLANE];
    logic              r_deg;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    assign w_m[0] = i_m_00;
    assign w_m[1] = i_m_01;
    assign w_m[2] = i_m_02;
    assign w_m[3] = i_m_10;
    assign w_m[4] = i_m_11;
    assign w_m[5] = i_m_12;
    assign w_m[6] = i_m_20;
    assign w_m[7] = i_m_21;
    assign w_m[8] = i_m_22;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .NW        (NW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_m     (w_m),
        .o_a2    (w_a2),
        .o_n     (w_n),
        .o_side  (w_side)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        logic [QW-1:0] q;
        logic [SW:0]   rp1;
        logic [OW-1:0] mag;

        rmq_div #(
            .AW (AW),
            .NW (NW),
            .QW (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a2  (w_a2[l]),
            .i_n   (w_n),
            .o_q   (q)
        );

        rmq_isqrt #(
            .QW (QW),
            .SW (SW)
        ) u_isqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    (q),
            .o_root (w_root[l])
        );

        assign rp1 = {1'b0, w_root[l]} + (SW+1)'(1);
        assign mag = OW'(rp1[SW:1]);

        always_comb begin
            if (r_side[LAT-1].neg[l]) begin
                n_quat[l] = QUAT_W'(~mag + OW'(1));
            end else begin
                n_quat[l] = QUAT_W'(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_side[k] <= '0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_side[0] <= w_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_out_vld <= r_side[LAT-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg <= r_side[LAT-1].deg;
            if (r_side[LAT-1].deg) begin
                r_quat[0] <= ONE_Q;
                for (int i = 1; i < NLANE; i++) begin
                    r_quat[i] <= '0;
                end
            end else begin
                r_quat <= n_quat;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_quat_w     = r_quat[0];
    assign o_quat_x     = r_quat[1];
    assign o_quat_y     = r_quat[2];
    assign o_quat_z     = r_quat[3];
    assign o_degenerate = r_deg;

endmodule
